>>> design/hsi2rgb_pkg.sv
// Package for the HSI to RGB converter: widths, sector codes and the
// sector ratio table, built at elaboration. No dependencies.
package hsi2rgb_pkg;

  localparam int HUE_FRAC_BITS   = 4;
  localparam int RATIO_FRAC_BITS = 14;

  localparam int HUE_W   = 16;
  localparam int LEVEL_W = 10;
  localparam int Q8_W    = 9;
  localparam int CHAN_W  = 8;

  localparam int THIRD     = 120 << HUE_FRAC_BITS;
  localparam int SIXTY     = 60 << HUE_FRAC_BITS;
  localparam int ROM_DEPTH = THIRD;
  localparam int ADDR_W    = $clog2(ROM_DEPTH);

  // hue / THIRD = (hue >> (3 + HUE_FRAC_BITS)) / 15
  localparam int X_SHIFT = 3 + HUE_FRAC_BITS;
  localparam int X_W     = HUE_W - X_SHIFT;
  localparam int REC15   = 2185;
  localparam int REC15_SH = 15;
  localparam int REC3    = 683;
  localparam int REC3_SH = 11;
  localparam int Q_W     = $clog2((65535 / THIRD) + 1);

  localparam int RATIO_W = RATIO_FRAC_BITS + 3;
  localparam int FACT_W  = RATIO_FRAC_BITS + 11;
  localparam int I85_W   = 15;
  localparam int PROD_W  = I85_W + FACT_W - 1;
  localparam int OUT_SH  = 16 + RATIO_FRAC_BITS;

  localparam logic [1:0] SECTOR_RG = 2'd0;
  localparam logic [1:0] SECTOR_GB = 2'd1;
  localparam logic [1:0] SECTOR_BR = 2'd2;

  localparam logic [63:0] Q28_ONE = 64'd1 << 28;
  localparam logic [63:0] PI_Q28  = 64'd843314857;
  localparam logic [63:0] DEG_DEN = 64'd180 << HUE_FRAC_BITS;

  typedef logic signed [RATIO_W-1:0] ratio_t;
  typedef ratio_t ratio_rom_t [ROM_DEPTH];

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] deg_to_rad_q28(input logic [63:0] a);
    return (a * PI_Q28 + DEG_DEN / 2) / DEG_DEN;
  endfunction

  function automatic logic signed [63:0] cos_q28(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic signed [63:0] sum;
    x2  = (x * x) >> 28;
    t   = Q28_ONE;
    sum = signed'(Q28_ONE);
    for (int k = 1; k <= 12; k++) begin
      t = udiv64((t * x2) >> 28, 64'((2 * k - 1) * (2 * k)));
      if (k % 2 == 1) begin
        sum = sum - signed'(t);
      end else begin
        sum = sum + signed'(t);
      end
    end
    return sum;
  endfunction

  function automatic ratio_t sector_ratio(input int h);
    logic [63:0] other;
    logic signed [63:0] cn;
    logic signed [63:0] cd;
    logic signed [63:0] r;
    logic [63:0] mag;
    logic [63:0] den;
    logic [63:0] q;
    logic neg;
    other = (h <= SIXTY) ? 64'(SIXTY - h) : 64'(h - SIXTY);
    cn    = cos_q28(deg_to_rad_q28(64'(h)));
    cd    = cos_q28(deg_to_rad_q28(other));
    neg   = cn < 0;
    if (cd < signed'(Q28_ONE >> 2)) begin
      cd = signed'(Q28_ONE >> 2);
    end
    den = unsigned'(cd);
    mag = unsigned'(neg ? -cn : cn) << RATIO_FRAC_BITS;
    q   = udiv64(mag + (den >> 1), den);
    if (q > (64'd4 << RATIO_FRAC_BITS)) begin
      q = 64'd4 << RATIO_FRAC_BITS;
    end
    r = neg ? -signed'(q) : signed'(q);
    if (r < -(64'sd1 <<< RATIO_FRAC_BITS)) begin
      r = -(64'sd1 <<< RATIO_FRAC_BITS);
    end
    if (r > (64'sd2 <<< RATIO_FRAC_BITS)) begin
      r = 64'sd2 <<< RATIO_FRAC_BITS;
    end
    return RATIO_W'(r);
  endfunction

  function automatic ratio_rom_t build_ratio_rom();
    ratio_rom_t rom;
    for (int a = 0; a < ROM_DEPTH; a++) begin
      rom[a] = sector_ratio(a);
    end
    return rom;
  endfunction

endpackage

>>> design/hsi_to_rgb_convert.sv
// HSI to RGB converter, top level: six-stage pipeline with ratio ROM.
// Depends on hsi2rgb_pkg.
//
//  channel | dir | tdata fields (low bit up)                      | tuser
//  in_     | in  | hue[15:0] saturation[25:16] intensity[35:26]   | -
//  out_    | out | red[7:0] green[15:8] blue[23:16]               | -
//
// One colour per clock when the output is not stalled by out_tready.
// Stage 2 to 3 is the registered read of the 1920-entry ratio ROM; the
// widest step is the 15 x 24 bit level multiply in stage 4 to 5.
// Reset clears only the valid bits. Each stage holds while the stage after
// it is full and stalled, so bubbles close up and input keeps flowing.
module hsi_to_rgb_convert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // hue[15:0], saturation[25:16], intensity[35:26]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);
  import hsi2rgb_pkg::*;

  localparam ratio_rom_t RATIO_ROM = build_ratio_rom();
  localparam logic signed [FACT_W-1:0] ONE_F = FACT_W'(1) <<< (RATIO_FRAC_BITS + 8);

  logic en1, en2, en3, en4, en5, en_out;

  // stage 1
  logic             v1_r;
  logic [HUE_W-1:0] hue1_r;
  logic [Q8_W-1:0]  s1_r, i1_r;
  logic [Q_W-1:0]   q1_r;
  // stage 2
  logic              v2_r;
  logic [ADDR_W-1:0] addr2_r;
  logic [1:0]        sec2_r;
  logic [Q8_W-1:0]   s2_r, i2_r;
  // stage 3
  logic            v3_r;
  ratio_t          ratio3_r;
  logic [1:0]      sec3_r;
  logic [Q8_W-1:0] s3_r, i3_r;
  // stage 4
  logic                     v4_r;
  logic signed [FACT_W-1:0] fa4_r, fb4_r, fc4_r;
  logic [I85_W-1:0]         i85_4_r;
  logic [1:0]               sec4_r;
  // stage 5
  logic              v5_r;
  logic [PROD_W-1:0] pa5_r, pb5_r, pc5_r;
  logic [1:0]        sec5_r;
  // output
  logic        out_valid_r;
  logic [23:0] out_data_r;

  assign en_out    = !out_valid_r || out_tready;
  assign en5       = !v5_r || en_out;
  assign en4       = !v4_r || en5;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  // stage 1: clamp, coarse hue / third
  logic [HUE_W-1:0]   hue_in;
  logic [LEVEL_W-1:0] sat_in, int_in;
  logic [Q8_W-1:0]    s1_nxt, i1_nxt;
  logic [X_W-1:0]     x_in;
  logic [X_W+11:0]    xq_prod;
  logic [Q_W-1:0]     q1_nxt;

  always_comb begin
    hue_in  = in_tdata[15:0];
    sat_in  = in_tdata[25:16];
    int_in  = in_tdata[35:26];
    s1_nxt  = (sat_in > LEVEL_W'(256)) ? Q8_W'(256) : sat_in[Q8_W-1:0];
    i1_nxt  = (int_in > LEVEL_W'(256)) ? Q8_W'(256) : int_in[Q8_W-1:0];
    x_in    = X_W'(hue_in >> X_SHIFT);
    xq_prod = (X_W + 12)'(x_in) * (X_W + 12)'(REC15);
    q1_nxt  = Q_W'(xq_prod >> REC15_SH);
  end

  // stage 2: offset within the sector and sector number
  logic [HUE_W-1:0] rem2_nxt;
  logic [Q_W+10:0]  q3_prod;
  logic [Q_W-1:0]   q3;
  logic [Q_W-1:0]   qm3;
  logic [1:0]       sec2_nxt;

  always_comb begin
    rem2_nxt = hue1_r - HUE_W'(HUE_W'(q1_r) * HUE_W'(THIRD));
    q3_prod  = (Q_W + 11)'(q1_r) * (Q_W + 11)'(REC3);
    q3       = Q_W'(q3_prod >> REC3_SH);
    qm3      = q1_r - Q_W'(q3 * Q_W'(3));
    sec2_nxt = qm3[1:0];
  end

  // stage 3 to 4: channel factors
  logic signed [FACT_W-1:0] s_sx, r_sx, sr;
  logic signed [FACT_W-1:0] fa_nxt, fb_nxt, fc_nxt;

  always_comb begin
    s_sx   = FACT_W'(signed'({1'b0, s3_r}));
    r_sx   = FACT_W'(ratio3_r);
    sr     = FACT_W'(s_sx * r_sx);
    fa_nxt = ONE_F + sr;
    fb_nxt = ONE_F + (s_sx <<< RATIO_FRAC_BITS) - sr;
    fc_nxt = (FACT_W'(256) - s_sx) <<< RATIO_FRAC_BITS;
  end

  // stage 4 to 5: level products, negative factors floor at zero
  logic [FACT_W-2:0] ua, ub, uc;

  always_comb begin
    ua = fa4_r[FACT_W-1] ? '0 : fa4_r[FACT_W-2:0];
    ub = fb4_r[FACT_W-1] ? '0 : fb4_r[FACT_W-2:0];
    uc = fc4_r[FACT_W-1] ? '0 : fc4_r[FACT_W-2:0];
  end

  // stage 5 to output: scale, clamp, channel roles
  logic [CHAN_W-1:0] la, lb, lc;
  logic [23:0]       out_nxt;

  function automatic logic [CHAN_W-1:0] scale_level(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] v;
    v = p >> OUT_SH;
    return (v > PROD_W'(255)) ? CHAN_W'(255) : v[CHAN_W-1:0];
  endfunction

  always_comb begin
    la = scale_level(pa5_r);
    lb = scale_level(pb5_r);
    lc = scale_level(pc5_r);
    unique case (sec5_r)
      SECTOR_RG: out_nxt = {lc, lb, la};
      SECTOR_GB: out_nxt = {lb, la, lc};
      SECTOR_BR: out_nxt = {la, lc, lb};
      default:   out_nxt = {lc, lb, la};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_tvalid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en4)    v4_r        <= v3_r;
      if (en5)    v5_r        <= v4_r;
      if (en_out) out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      hue1_r <= hue_in;
      s1_r   <= s1_nxt;
      i1_r   <= i1_nxt;
      q1_r   <= q1_nxt;
    end
    if (en2) begin
      addr2_r <= rem2_nxt[ADDR_W-1:0];
      sec2_r  <= sec2_nxt;
      s2_r    <= s1_r;
      i2_r    <= i1_r;
    end
    if (en3) begin
      ratio3_r <= RATIO_ROM[addr2_r];
      sec3_r   <= sec2_r;
      s3_r     <= s2_r;
      i3_r     <= i2_r;
    end
    if (en4) begin
      fa4_r   <= fa_nxt;
      fb4_r   <= fb_nxt;
      fc4_r   <= fc_nxt;
      i85_4_r <= I85_W'(I85_W'(i3_r) * I85_W'(85));
      sec4_r  <= sec3_r;
    end
    if (en5) begin
      pa5_r  <= PROD_W'(i85_4_r) * PROD_W'(ua);
      pb5_r  <= PROD_W'(i85_4_r) * PROD_W'(ub);
      pc5_r  <= PROD_W'(i85_4_r) * PROD_W'(uc);
      sec5_r <= sec4_r;
    end
    if (en_out) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted transfer did not enter stage 1");

  a_sector_code: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (sec2_r == SECTOR_RG || sec2_r == SECTOR_GB || sec2_r == SECTOR_BR))
    else $error("sector number out of range");

  a_rom_index: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (32'(addr2_r) < ROM_DEPTH))
    else $error("ratio ROM address beyond table");

  a_factor_sign: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (!fa4_r[FACT_W-1] && !fb4_r[FACT_W-1] && !fc4_r[FACT_W-1]))
    else $error("channel factor went negative");
`endif

endmodule
